### rtl/wsc_pkg.sv
// shared types and constants for the weighted subset sum counter
// no dependencies; used by every module of the block
package wsc_pkg;

  localparam int unsigned VALUE_W = 13;
  localparam int unsigned COUNT_W = 30;
  localparam logic [COUNT_W-1:0] MODULUS = 30'd998244353;

  typedef enum logic [4:0] {
    S_INIT  = 5'b00001,
    S_IDLE  = 5'b00010,
    S_SWEEP = 5'b00100,
    S_DRAIN = 5'b01000,
    S_WAIT  = 5'b10000
  } state_e;

  // control that travels with each entry through the update pipeline
  typedef struct packed {
    logic valid;
    logic last;
    logic hit;
    logic zero;
  } tag_t;

endpackage

### rtl/wsc_count_ram.sv
// count table: one write port and two registered read ports
// depends on wsc_pkg for the count width
module wsc_count_ram import wsc_pkg::*; #(
  parameter int unsigned DEPTH = 4097,
  parameter int unsigned AW    = 13
) (
  input  logic               clk_i,
  input  logic               we_i,
  input  logic [AW-1:0]      wa_i,
  input  logic [COUNT_W-1:0] wd_i,
  input  logic [AW-1:0]      ra_i,
  input  logic [AW-1:0]      rb_i,
  output logic [COUNT_W-1:0] qa_o,
  output logic [COUNT_W-1:0] qb_o
);

  logic [COUNT_W-1:0] mem [DEPTH];
  logic [COUNT_W-1:0] qa_q;
  logic [COUNT_W-1:0] qb_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[wa_i] <= wd_i;
    end
    qa_q <= mem[ra_i];
    qb_q <= mem[rb_i];
  end

  assign qa_o = qa_q;
  assign qb_o = qb_q;

endmodule

### rtl/wsc_mod_update.sv
// two-stage modular update: (2*x + y) mod prime, y optionally dropped
// depends on wsc_pkg for the modulus, widths and the pipeline tag
module wsc_mod_update import wsc_pkg::*; #(
  parameter int unsigned AW = 13
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic [COUNT_W-1:0] x_i,
  input  logic [COUNT_W-1:0] y_i,
  input  logic               y_en_i,
  input  tag_t               tag_i,
  input  logic [AW-1:0]      addr_i,
  output logic [COUNT_W-1:0] sum_o,
  output tag_t               tag_o,
  output logic [AW-1:0]      addr_o
);

  logic [COUNT_W:0]   dbl_raw;
  logic [COUNT_W-1:0] dbl_d;
  logic [COUNT_W-1:0] dbl_q;
  logic [COUNT_W-1:0] y_q;
  tag_t               tag_q;
  logic [AW-1:0]      addr_q;
  logic [COUNT_W:0]   add_raw;

  // first stage: double and fold back below the modulus
  always_comb begin
    dbl_raw = {x_i, 1'b0};
    if (dbl_raw >= {1'b0, MODULUS}) begin
      dbl_d = COUNT_W'(dbl_raw - {1'b0, MODULUS});
    end else begin
      dbl_d = dbl_raw[COUNT_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag_q <= '0;
    end else begin
      tag_q <= tag_i;
    end
  end

  always_ff @(posedge clk_i) begin
    dbl_q  <= dbl_d;
    y_q    <= y_en_i ? y_i : '0;
    addr_q <= addr_i;
  end

  // second stage: add the shifted entry and fold again
  always_comb begin
    add_raw = {1'b0, dbl_q} + {1'b0, y_q};
    if (add_raw >= {1'b0, MODULUS}) begin
      sum_o = COUNT_W'(add_raw - {1'b0, MODULUS});
    end else begin
      sum_o = add_raw[COUNT_W-1:0];
    end
  end

  assign tag_o  = tag_q;
  assign addr_o = addr_q;

endmodule

### rtl/weighted_subset_sum_counter_core.sv
// weighted subset sum counter, top level: sweep control, count table and update pipeline
// depends on wsc_pkg, wsc_count_ram and wsc_mod_update
//
// After reset the block clears its count table, one entry per cycle from the highest
// sum down to 0, and stalls input until that is done; target_sum writes are taken at any time.
// For each item the table is then swept from the highest sum down to 0 with one
// read-modify-write of the single table memory per cycle, the three-deep update
// pipeline drains, and the block returns to idle, where the next item is taken. The
// item marked last produces one answer transaction and leaves the table back in its
// cleared state as part of the same sweep, so no extra pass is spent. The answer sits
// in an output register, and the block keeps taking items while it waits there; if
// that register still holds an unaccepted answer, the block first waits until it is taken.
module weighted_subset_sum_counter_core import wsc_pkg::*; #(
  parameter int unsigned MAX_SUM = 4096
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [VALUE_W-1:0] item_value_i,
  input  logic               last_item_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [COUNT_W-1:0] answer_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [VALUE_W-1:0] target_sum_i
);

  localparam int unsigned DEPTH = MAX_SUM + 1;
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned CW    = (AW > VALUE_W) ? AW : VALUE_W;
  localparam logic [AW-1:0] TOP_ADDR = AW'(MAX_SUM);

  state_e state_q, state_d;
  logic [AW-1:0]      j_q, j_d;
  logic [VALUE_W-1:0] a_q, a_d;
  logic               last_q, last_d;
  logic [1:0]         drain_q, drain_d;
  logic [VALUE_W-1:0] target_q;
  logic [COUNT_W-1:0] ans_q, ans_d;
  logic               out_valid_q, out_valid_d;
  logic [COUNT_W-1:0] answer_q, answer_d;

  logic [CW-1:0]      j_ext;
  logic [CW-1:0]      a_ext;
  logic               y_en;
  logic [AW-1:0]      rb_addr;
  tag_t               s0_tag;
  tag_t               s1_tag_q;
  logic [AW-1:0]      s1_addr_q;
  logic               s1_yen_q;

  logic [COUNT_W-1:0] qa, qb;
  logic [COUNT_W-1:0] sum;
  tag_t               s2_tag;
  logic [AW-1:0]      s2_addr;

  logic               we;
  logic [AW-1:0]      wa;
  logic [COUNT_W-1:0] wd;
  logic               in_fire;
  logic               slot_free;
  logic               load_out;

  assign in_stall_o  = (state_q != S_IDLE);
  assign in_fire     = in_valid_i && !in_stall_o;
  assign cfg_ready_o = 1'b1;
  assign slot_free   = !out_valid_q || !out_stall_i;

  // read addresses for the entry and its shifted partner
  always_comb begin
    j_ext   = CW'(j_q);
    a_ext   = CW'(a_q);
    y_en    = (j_ext >= a_ext);
    rb_addr = y_en ? AW'(j_ext - a_ext) : j_q;
    s0_tag.valid = (state_q == S_SWEEP);
    s0_tag.last  = last_q;
    s0_tag.hit   = (j_ext == CW'(target_q));
    s0_tag.zero  = (j_q == '0);
  end

  wsc_count_ram #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_ram (
    .clk_i (clk_i),
    .we_i  (we),
    .wa_i  (wa),
    .wd_i  (wd),
    .ra_i  (j_q),
    .rb_i  (rb_addr),
    .qa_o  (qa),
    .qb_o  (qb)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_tag_q <= '0;
    end else begin
      s1_tag_q <= s0_tag;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_addr_q <= j_q;
    s1_yen_q  <= y_en;
  end

  wsc_mod_update #(
    .AW (AW)
  ) u_update (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .x_i    (qa),
    .y_i    (qb),
    .y_en_i (s1_yen_q),
    .tag_i  (s1_tag_q),
    .addr_i (s1_addr_q),
    .sum_o  (sum),
    .tag_o  (s2_tag),
    .addr_o (s2_addr)
  );

  // write back, or the table clear during init; the last sweep stores the cleared table instead of the update
  always_comb begin
    if (state_q == S_INIT) begin
      we = 1'b1;
      wa = j_q;
      wd = (j_q == '0) ? COUNT_W'(1) : '0;
    end else begin
      we = s2_tag.valid;
      wa = s2_addr;
      if (s2_tag.last) begin
        wd = s2_tag.zero ? COUNT_W'(1) : '0;
      end else begin
        wd = sum;
      end
    end
  end

  always_comb begin
    state_d  = state_q;
    j_d      = j_q;
    a_d      = a_q;
    last_d   = last_q;
    drain_d  = drain_q;
    ans_d    = ans_q;
    load_out = 1'b0;

    if (s2_tag.valid && s2_tag.hit) begin
      ans_d = sum;
    end

    unique case (state_q)
      S_INIT: begin
        if (j_q == '0) begin
          state_d = S_IDLE;
        end else begin
          j_d = j_q - AW'(1);
        end
      end
      S_IDLE: begin
        if (in_fire) begin
          a_d     = item_value_i;
          last_d  = last_item_i;
          j_d     = TOP_ADDR;
          ans_d   = '0;
          state_d = S_SWEEP;
        end
      end
      S_SWEEP: begin
        if (j_q == '0) begin
          drain_d = '0;
          state_d = S_DRAIN;
        end else begin
          j_d = j_q - AW'(1);
        end
      end
      S_DRAIN: begin
        if (drain_q == 2'd2) begin
          if (!last_q) begin
            state_d = S_IDLE;
          end else if (slot_free) begin
            load_out = 1'b1;
            state_d  = S_IDLE;
          end else begin
            state_d = S_WAIT;
          end
        end else begin
          drain_d = drain_q + 2'd1;
        end
      end
      S_WAIT: begin
        if (slot_free) begin
          load_out = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // output register
  always_comb begin
    out_valid_d = out_valid_q;
    answer_d    = answer_q;
    if (load_out) begin
      out_valid_d = 1'b1;
      answer_d    = ans_q;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_INIT;
      j_q         <= TOP_ADDR;
      drain_q     <= '0;
      last_q      <= 1'b0;
      target_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      j_q         <= j_d;
      drain_q     <= drain_d;
      last_q      <= last_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        target_q <= target_sum_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    a_q      <= a_d;
    ans_q    <= ans_d;
    answer_q <= answer_d;
  end

  assign out_valid_o = out_valid_q;
  assign answer_o    = answer_q;

endmodule
